[rtl/core/lru_occupancy_evict_table_top_macros.svh]
// Assertion macros for the LRU occupancy eviction table.
`ifndef LRU_OCCUPANCY_EVICT_TABLE_TOP_MACROS_SVH
`define LRU_OCCUPANCY_EVICT_TABLE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define LOET_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("assertion failed");
`define LOET_ASSERT_NEXT(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) else $error("assertion failed");
`else
`define LOET_ASSERT(lbl, clk, rstn, prop)
`define LOET_ASSERT_NEXT(lbl, clk, rstn, a, b)
`endif
`endif

[rtl/core/loet_pkg.sv]
// ----------------------------------------------------------------------------
// loet_pkg
// Types and codes of the LRU occupancy eviction table.
// ----------------------------------------------------------------------------
package loet_pkg;

  localparam logic [2:0] REQ_UPDATE = 3'd0;
  localparam logic [2:0] REQ_STATUS = 3'd1;
  localparam logic [2:0] REQ_REMOVE = 3'd2;
  localparam logic [2:0] REQ_EVICT  = 3'd3;
  localparam logic [2:0] REQ_QUERY  = 3'd4;

  localparam logic [1:0] ST_PENDING    = 2'd0;
  localparam logic [1:0] ST_PROCESSING = 2'd1;
  localparam logic [1:0] ST_COMPLETED  = 2'd2;
  localparam logic [1:0] ST_OTHER      = 2'd3;

  localparam logic [1:0] REG_MAX_ITEMS = 2'd0;
  localparam logic [1:0] REG_MAX_MEM   = 2'd1;
  localparam logic [1:0] REG_FRACTION  = 2'd2;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SCAN   = 7'b0000010,
    S_STSCAN = 7'b0000100,
    S_APPLY  = 7'b0001000,
    S_THR    = 7'b0010000,
    S_DROP   = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_e;

endpackage

[rtl/core/lru_occupancy_evict_table_top.sv]
// ----------------------------------------------------------------------------
// lru_occupancy_evict_table_top
// LRU request table with occupancy totals and threshold-driven eviction.
// The result strobe follows accept once both tables are scanned; a new item is
// taken only while busy is low. An evict scans again for each removal and strobes
// one result per removed entry, then a final one with last_o set.
// Reset clears valid bits, totals and entry count and loads the config registers
`include "lru_occupancy_evict_table_top_macros.svh"

module lru_occupancy_evict_table_top #(
  parameter int STATS_ENTRIES  = 16,
  parameter int STATUS_ENTRIES = 16,
  parameter int SEQ_LEN_BITS   = 20
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [3:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  logic                    start,
  output logic                    busy,
  input  logic [2:0]              req_type_i,
  input  logic [31:0]             request_id_i,
  input  logic [SEQ_LEN_BITS-1:0] seq_len_i,
  input  logic [1:0]              status_value_i,
  output logic                    strobe_o,
  output logic                    found_o,
  output logic [SEQ_LEN_BITS-1:0] item_count_o,
  output logic [SEQ_LEN_BITS:0]   memory_mb_o,
  output logic [1:0]              status_out_o,
  output logic [23:0]             total_items_o,
  output logic [24:0]             total_memory_mb_o,
  output logic [$clog2(STATS_ENTRIES+1)-1:0] entry_count_o,
  output logic                    evict_needed_o,
  output logic [31:0]             evicted_id_o,
  output logic [$clog2(STATS_ENTRIES+1)-1:0] evicted_count_o,
  output logic                    table_full_o,
  output logic                    last_o
);
  import loet_pkg::*;

  localparam int SI = $clog2(STATS_ENTRIES);
  localparam int TI = $clog2(STATUS_ENTRIES);
  localparam int CW = $clog2(STATS_ENTRIES+1);
  localparam int SC = $clog2(STATS_ENTRIES+1);
  localparam int TC = $clog2(STATUS_ENTRIES+1);
  localparam int IW = 25;
  localparam int MW = 26;

  logic [23:0] max_items_q;
  logic [24:0] max_mem_q;
  logic [8:0]  frac_q;

  logic [STATS_ENTRIES-1:0]  sv_q;
  logic [31:0]               skey_q [STATS_ENTRIES];
  logic [SEQ_LEN_BITS-1:0]   sitems_q [STATS_ENTRIES];
  logic [SI-1:0]             rank_q [STATS_ENTRIES];
  logic [STATUS_ENTRIES-1:0] tv_q;
  logic [31:0]               tkey_q [STATUS_ENTRIES];
  logic [1:0]                tcode_q [STATUS_ENTRIES];
  logic [IW-1:0]             itot_q;
  logic [MW-1:0]             mtot_q;
  logic [CW-1:0]             cnt_q;

  state_e                    st_q;
  logic [2:0]                typ_q;
  logic [31:0]               key_q;
  logic [SEQ_LEN_BITS-1:0]   len_q;
  logic [1:0]                sval_q;
  logic [SC-1:0]             si_q;
  logic [TC-1:0]             ti_q;
  logic                      shit_q, sfree_q, thit_q, tfree_q;
  logic [SI-1:0]             sidx_q, sfidx_q;
  logic [TI-1:0]             tidx_q, tfidx_q;
  logic                      best_ok_q;
  logic [SI-1:0]             best_q;
  logic [CW-1:0]             nev_q;
  logic [32:0]               thi_q, thm_q;

  logic                      o_stb_q, o_found_q, o_full_q, o_last_q;
  logic [SEQ_LEN_BITS-1:0]   o_items_q;
  logic [1:0]                o_stat_q;
  logic [31:0]               o_eid_q;
  logic [CW-1:0]             o_ecnt_q;

  // Config port
  logic wr;
  assign wr = psel & penable & pwrite;
  assign pready = 1'b1;
  always_comb begin
    case (paddr[3:2])
      REG_MAX_ITEMS: prdata = {8'd0, max_items_q};
      REG_MAX_MEM:   prdata = {7'd0, max_mem_q};
      REG_FRACTION:  prdata = {23'd0, frac_q};
      default:       prdata = 32'd0;
    endcase
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_items_q <= 24'd16384;
      max_mem_q   <= 25'd32768;
      frac_q      <= 9'd230;
    end else if (wr) begin
      case (paddr[3:2])
        REG_MAX_ITEMS: max_items_q <= pwdata[23:0];
        REG_MAX_MEM:   max_mem_q   <= pwdata[24:0];
        REG_FRACTION:  frac_q      <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  // Shared compare unit: one stats entry and one status entry per cycle in a lookup scan
  logic [SI-1:0] sptr;
  logic [TI-1:0] tptr;
  logic [31:0]   tcmp_key;
  logic          s_match, t_match, t_keyhit;
  logic [1:0]    pcode;
  assign sptr = si_q[SI-1:0];
  assign tptr = ti_q[TI-1:0];
  assign s_match = sv_q[sptr] && skey_q[sptr] == key_q;
  assign tcmp_key = (typ_q == REQ_EVICT) ? skey_q[sptr] : key_q;
  assign t_keyhit = tv_q[tptr] && tkey_q[tptr] == tcmp_key;
  assign t_match = t_keyhit;
  assign pcode = thit_q ? tcode_q[tidx_q] : ST_PENDING;

  logic [SEQ_LEN_BITS:0] old_mem, new_mem;
  assign old_mem = {sitems_q[sidx_q], 1'b0};
  assign new_mem = {len_q, 1'b0};

  logic [SI-1:0] ref_rank;
  assign ref_rank = rank_q[sidx_q];

  logic s_end, t_end;
  assign s_end = si_q == SC'(STATS_ENTRIES - 1);
  assign t_end = ti_q == TC'(STATUS_ENTRIES - 1);

  assign busy = st_q != S_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_IDLE;
      sv_q    <= '0;
      tv_q    <= '0;
      itot_q  <= '0;
      mtot_q  <= '0;
      cnt_q   <= '0;
      o_stb_q <= 1'b0;
    end else begin
      o_stb_q <= 1'b0;
      case (st_q)
        S_IDLE: if (start) begin
          typ_q <= req_type_i; key_q <= request_id_i;
          len_q <= seq_len_i;  sval_q <= status_value_i;
          si_q <= '0; ti_q <= '0; nev_q <= '0;
          shit_q <= 1'b0; sfree_q <= 1'b0; thit_q <= 1'b0; tfree_q <= 1'b0;
          best_ok_q <= 1'b0;
          st_q <= (req_type_i == REQ_EVICT) ? S_THR : S_SCAN;
        end
        S_THR: begin
          thi_q <= 33'((34'(max_items_q) * 34'(frac_q)) >> 8);
          thm_q <= 33'((34'(max_mem_q) * 34'(frac_q)) >> 8);
          st_q <= S_DROP;
        end
        S_SCAN: begin
          if (typ_q == REQ_EVICT) begin
            // find status of entry sptr, then rank compare
            if (ti_q == '0) thit_q <= 1'b0;
            if (t_match && !thit_q) begin thit_q <= 1'b1; tidx_q <= tptr; end
            if (t_end) begin
              ti_q <= '0;
              st_q <= S_STSCAN;
            end else ti_q <= ti_q + TC'(1);
          end else begin
            if (s_match && !shit_q) begin shit_q <= 1'b1; sidx_q <= sptr; end
            if (!sv_q[sptr] && !sfree_q) begin sfree_q <= 1'b1; sfidx_q <= sptr; end
            if (t_match && !thit_q) begin thit_q <= 1'b1; tidx_q <= tptr; end
            if (!tv_q[tptr] && !tfree_q) begin tfree_q <= 1'b1; tfidx_q <= tptr; end
            if (!s_end) si_q <= si_q + SC'(1);
            if (!t_end) ti_q <= ti_q + TC'(1);
            if (s_end && t_end) st_q <= S_APPLY;
          end
        end
        S_STSCAN: begin
          // evict candidate check for entry sptr
          if (sv_q[sptr] && (pcode == ST_PENDING || pcode == ST_COMPLETED) &&
              (!best_ok_q || rank_q[sptr] > rank_q[best_q])) begin
            best_ok_q <= 1'b1; best_q <= sptr;
          end
          thit_q <= 1'b0;
          if (s_end) begin
            si_q <= '0;
            st_q <= S_APPLY;
          end else begin
            si_q <= si_q + SC'(1);
            st_q <= S_SCAN;
          end
        end
        S_DROP: begin
          if (((33'(itot_q) > thi_q) || (33'(mtot_q) > thm_q)) &&
              nev_q != CW'(STATS_ENTRIES)) begin
            si_q <= '0; ti_q <= '0; best_ok_q <= 1'b0; thit_q <= 1'b0;
            st_q <= S_SCAN;
          end else begin
            o_eid_q <= '0; o_ecnt_q <= nev_q; o_last_q <= 1'b1;
            o_found_q <= 1'b0; o_items_q <= '0; o_stat_q <= '0; o_full_q <= 1'b0;
            st_q <= S_OUT;
          end
        end
        S_APPLY: begin
          o_found_q <= 1'b0; o_items_q <= '0; o_stat_q <= '0; o_full_q <= 1'b0;
          o_eid_q <= '0; o_ecnt_q <= '0; o_last_q <= 1'b1;
          st_q <= S_OUT;
          case (typ_q)
            REQ_UPDATE: begin
              if (shit_q) begin
                sitems_q[sidx_q] <= len_q;
                itot_q <= itot_q - IW'(sitems_q[sidx_q]) + IW'(len_q);
                mtot_q <= mtot_q - MW'(old_mem) + MW'(new_mem);
                for (int i = 0; i < STATS_ENTRIES; i++)
                  if (sv_q[i] && SI'(i) != sidx_q && rank_q[i] < ref_rank)
                    rank_q[i] <= rank_q[i] + SI'(1);
                rank_q[sidx_q] <= '0;
              end else if (sfree_q) begin
                sv_q[sfidx_q] <= 1'b1; skey_q[sfidx_q] <= key_q;
                sitems_q[sfidx_q] <= len_q;
                itot_q <= itot_q + IW'(len_q);
                mtot_q <= mtot_q + MW'(new_mem);
                cnt_q <= cnt_q + CW'(1);
                for (int i = 0; i < STATS_ENTRIES; i++)
                  if (sv_q[i]) rank_q[i] <= rank_q[i] + SI'(1);
                rank_q[sfidx_q] <= '0;
              end else o_full_q <= 1'b1;
            end
            REQ_STATUS: begin
              if (thit_q) tcode_q[tidx_q] <= sval_q;
              else if (tfree_q) begin
                tv_q[tfidx_q] <= 1'b1; tkey_q[tfidx_q] <= key_q;
                tcode_q[tfidx_q] <= sval_q;
              end else o_full_q <= 1'b1;
            end
            REQ_REMOVE, REQ_EVICT: begin
              if ((typ_q == REQ_REMOVE && shit_q) ||
                  (typ_q == REQ_EVICT && best_ok_q)) begin
                // drop the selected entry; for evict, rescan to remove entry best_q
                if (typ_q == REQ_EVICT) begin
                  sidx_q <= best_q; key_q <= skey_q[best_q];
                  st_q <= S_SCAN; si_q <= '0; ti_q <= '0;
                  typ_q <= REQ_REMOVE; shit_q <= 1'b0; thit_q <= 1'b0;
                  nev_q <= nev_q + CW'(1);
                  sfree_q <= 1'b1; // stops the free-slot search in the rescan
                end else begin
                  sv_q[sidx_q] <= 1'b0;
                  itot_q <= itot_q - IW'(sitems_q[sidx_q]);
                  mtot_q <= mtot_q - MW'(old_mem);
                  cnt_q <= cnt_q - CW'(1);
                  for (int i = 0; i < STATS_ENTRIES; i++)
                    if (sv_q[i] && rank_q[i] > ref_rank)
                      rank_q[i] <= rank_q[i] - SI'(1);
                  if (thit_q) tv_q[tidx_q] <= 1'b0;
                  o_found_q <= 1'b1;
                  if (nev_q != '0) begin
                    o_found_q <= 1'b0; o_last_q <= 1'b0;
                    o_eid_q <= key_q;
                  end
                end
              end else if (typ_q == REQ_EVICT) begin
                o_ecnt_q <= nev_q;
              end
            end
            REQ_QUERY: begin
              o_found_q <= shit_q;
              if (shit_q) o_items_q <= sitems_q[sidx_q];
              o_stat_q <= thit_q ? tcode_q[tidx_q] : ST_PENDING;
            end
            default: ;
          endcase
        end
        S_OUT: begin
          o_stb_q <= 1'b1;
          if (!o_last_q) begin
            typ_q <= REQ_EVICT;
            st_q <= S_DROP;
          end else st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  logic [32:0] thi_c, thm_c;
  assign thi_c = 33'((34'(max_items_q) * 34'(frac_q)) >> 8);
  assign thm_c = 33'((34'(max_mem_q) * 34'(frac_q)) >> 8);

  assign strobe_o          = o_stb_q;
  assign found_o           = o_found_q;
  assign item_count_o      = o_found_q ? o_items_q : '0;
  assign memory_mb_o       = o_found_q ? {o_items_q, 1'b0} : '0;
  assign status_out_o      = o_stat_q;
  assign total_items_o     = itot_q[23:0];
  assign total_memory_mb_o = mtot_q[24:0];
  assign entry_count_o     = cnt_q;
  assign evict_needed_o    = (33'(itot_q) > thi_c) || (33'(mtot_q) > thm_c);
  assign evicted_id_o      = o_eid_q;
  assign evicted_count_o   = o_ecnt_q;
  assign table_full_o      = o_full_q;
  assign last_o            = o_last_q;

  `LOET_ASSERT(a_strobe_busy, clk_i, rst_ni, strobe_o |-> !$past(st_q == S_IDLE))
  `LOET_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start && !busy, busy)
  `LOET_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q <= CW'(STATS_ENTRIES))
endmodule

[bench/lru_occupancy_evict_table_top_tb.sv]
// ----------------------------------------------------------------------------
// lru_occupancy_evict_table_top_tb
// Drives update, status, remove, evict, query and undefined-code items into the
// LRU table under several threshold settings and checks every result strobe
// against an in-bench model of the table, its totals and its eviction order.
// ----------------------------------------------------------------------------
module lru_occupancy_evict_table_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import loet_pkg::*;

  localparam int NENT = 16;
  localparam int WD_LIMIT = 40000;

  typedef struct packed {
    logic        found;
    logic [19:0] item_count;
    logic [20:0] memory_mb;
    logic [1:0]  status_out;
    logic [23:0] total_items;
    logic [24:0] total_memory_mb;
    logic [4:0]  entry_count;
    logic        evict_needed;
    logic [31:0] evicted_id;
    logic [4:0]  evicted_count;
    logic        table_full;
    logic        last;
  } table_res_t;

  class table_scoreboard;
    table_res_t  pending_q[$];
    int          errors;
    logic [23:0] cap_items;
    logic [24:0] cap_mem;
    logic [8:0]  frac;
    bit          s_vld[NENT];
    logic [31:0] s_key[NENT];
    logic [19:0] s_items[NENT];
    logic [20:0] s_mem[NENT];
    int unsigned s_rank[NENT];
    bit          t_vld[NENT];
    logic [31:0] t_key[NENT];
    logic [1:0]  t_code[NENT];
    logic [24:0] sum_items;
    logic [25:0] sum_mem;

    function new();
      errors = 0;
      cap_items = 24'd16384;
      cap_mem = 25'd32768;
      frac = 9'd230;
      sum_items = '0;
      sum_mem = '0;
      foreach (s_vld[i]) begin
        s_vld[i] = 0;
        t_vld[i] = 0;
        s_rank[i] = 0;
      end
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_MAX_ITEMS: cap_items = val[23:0];
        REG_MAX_MEM:   cap_mem = val[24:0];
        REG_FRACTION:  frac = val[8:0];
        default: ;
      endcase
    endfunction

    function int find_stat(logic [31:0] k);
      for (int i = 0; i < NENT; i++) if (s_vld[i] && s_key[i] == k) return i;
      return -1;
    endfunction

    function int find_status(logic [31:0] k);
      for (int i = 0; i < NENT; i++) if (t_vld[i] && t_key[i] == k) return i;
      return -1;
    endfunction

    function bit over_limit();
      logic [63:0] ti, tm;
      ti = (64'(cap_items) * 64'(frac)) >> 8;
      tm = (64'(cap_mem) * 64'(frac)) >> 8;
      return 64'(sum_items) > ti || 64'(sum_mem) > tm;
    endfunction

    function void fill(ref table_res_t r);
      int n;
      n = 0;
      foreach (s_vld[i]) n += s_vld[i];
      r.total_items = sum_items[23:0];
      r.total_memory_mb = sum_mem[24:0];
      r.entry_count = 5'(n);
      r.evict_needed = over_limit();
    endfunction

    function void drop(int e);
      int s;
      sum_items = sum_items - 25'(s_items[e]);
      sum_mem = sum_mem - 26'(s_mem[e]);
      s_vld[e] = 0;
      foreach (s_vld[i]) if (s_vld[i] && s_rank[i] > s_rank[e]) s_rank[i]--;
      s = find_status(s_key[e]);
      if (s >= 0) t_vld[s] = 0;
    endfunction

    function void note_item(logic [2:0] op, logic [31:0] k, logic [19:0] len,
                            logic [1:0] st);
      table_res_t r;
      int e, s, n, best;
      bit fresh;
      int unsigned old_rank;
      logic [1:0] c;
      r = '0;
      case (op)
        REQ_UPDATE: begin
          e = find_stat(k);
          fresh = 0;
          if (e < 0) begin
            for (int i = 0; i < NENT && e < 0; i++) if (!s_vld[i]) e = i;
            fresh = 1;
          end
          if (e < 0) begin
            r.table_full = 1;
          end else begin
            if (!fresh) begin
              sum_items = sum_items - 25'(s_items[e]);
              sum_mem = sum_mem - 26'(s_mem[e]);
            end
            old_rank = fresh ? 32'hFFFF_FFFF : s_rank[e];
            foreach (s_vld[i])
              if (s_vld[i] && i != e && s_rank[i] < old_rank) s_rank[i]++;
            s_vld[e] = 1;
            s_key[e] = k;
            s_items[e] = len;
            s_mem[e] = {len, 1'b0};
            s_rank[e] = 0;
            sum_items = sum_items + 25'(len);
            sum_mem = sum_mem + 26'({len, 1'b0});
          end
        end
        REQ_STATUS: begin
          s = find_status(k);
          for (int i = 0; i < NENT && s < 0; i++) if (!t_vld[i]) s = i;
          if (s < 0) begin
            r.table_full = 1;
          end else begin
            t_vld[s] = 1;
            t_key[s] = k;
            t_code[s] = st;
          end
        end
        REQ_REMOVE: begin
          e = find_stat(k);
          if (e >= 0) begin
            drop(e);
            r.found = 1;
          end
        end
        REQ_EVICT: begin
          n = 0;
          while (over_limit() && n < NENT) begin
            table_res_t ev;
            best = -1;
            for (int i = 0; i < NENT; i++) begin
              if (!s_vld[i]) continue;
              s = find_status(s_key[i]);
              c = (s >= 0) ? t_code[s] : ST_PENDING;
              if (c != ST_PENDING && c != ST_COMPLETED) continue;
              if (best < 0 || s_rank[i] > s_rank[best]) best = i;
            end
            if (best < 0) break;
            ev = '0;
            ev.evicted_id = s_key[best];
            drop(best);
            fill(ev);
            pending_q.push_back(ev);
            n++;
          end
          r.evicted_count = 5'(n);
        end
        REQ_QUERY: begin
          e = find_stat(k);
          if (e >= 0) begin
            r.found = 1;
            r.item_count = s_items[e];
            r.memory_mb = s_mem[e];
          end
          s = find_status(k);
          r.status_out = (s >= 0) ? t_code[s] : ST_PENDING;
        end
        default: ;
      endcase
      r.last = 1;
      fill(r);
      pending_q.push_back(r);
    endfunction

    function void cmp(string name, logic [31:0] x, logic [31:0] a);
      if (x !== a) begin
        $error("%s: expected %0h, got %0h", name, x, a);
        errors++;
      end
    endfunction

    function void check_result(table_res_t a);
      table_res_t x;
      if (pending_q.size() == 0) begin
        $error("result with no item outstanding");
        errors++;
        return;
      end
      x = pending_q.pop_front();
      cmp("found", x.found, a.found);
      cmp("item_count", x.item_count, a.item_count);
      cmp("memory_mb", x.memory_mb, a.memory_mb);
      cmp("status_out", x.status_out, a.status_out);
      cmp("total_items", x.total_items, a.total_items);
      cmp("total_memory_mb", x.total_memory_mb, a.total_memory_mb);
      cmp("entry_count", x.entry_count, a.entry_count);
      cmp("evict_needed", x.evict_needed, a.evict_needed);
      cmp("evicted_id", x.evicted_id, a.evicted_id);
      cmp("evicted_count", x.evicted_count, a.evicted_count);
      cmp("table_full", x.table_full, a.table_full);
      cmp("last", x.last, a.last);
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        start = 0;
  logic        busy;
  logic [2:0]  req_type_i = '0;
  logic [31:0] request_id_i = '0;
  logic [19:0] seq_len_i = '0;
  logic [1:0]  status_value_i = '0;
  logic        strobe_o, found_o, evict_needed_o, table_full_o, last_o;
  logic [19:0] item_count_o;
  logic [20:0] memory_mb_o;
  logic [1:0]  status_out_o;
  logic [23:0] total_items_o;
  logic [24:0] total_memory_mb_o;
  logic [4:0]  entry_count_o, evicted_count_o;
  logic [31:0] evicted_id_o;

  lru_occupancy_evict_table_top u_top (.*);

  always #10 clk_i = ~clk_i;

  table_scoreboard sb = new();
  logic [31:0] key_pool[24];
  bit          no_idle = 0;
  int          wd_count = 0;

  always @(posedge clk_i) begin
    if (rst_ni && strobe_o)
      sb.check_result('{found_o, item_count_o, memory_mb_o, status_out_o, total_items_o,
                        total_memory_mb_o, entry_count_o, evict_needed_o, evicted_id_o,
                        evicted_count_o, table_full_o, last_o});
    if (!rst_ni || strobe_o || (start && !busy)) wd_count <= 0;
    else wd_count <= wd_count + 1;
    if (wd_count >= WD_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic apb_write(logic [1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  task automatic send_item(logic [2:0] op, logic [31:0] k, logic [19:0] len,
                           logic [1:0] st);
    @(negedge clk_i);
    while (!no_idle && $urandom_range(99) < 14) @(negedge clk_i);
    while (busy) @(negedge clk_i);
    start <= 1;
    req_type_i <= op;
    request_id_i <= k;
    seq_len_i <= len;
    status_value_i <= st;
    @(posedge clk_i);
    sb.note_item(op, k, len, st);
    @(negedge clk_i);
    start <= 0;
  endtask

  task automatic drain();
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic send_random(int count);
    int pick;
    logic [2:0] op;
    logic [31:0] k;
    logic [19:0] len;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 35) op = REQ_UPDATE;
      else if (pick < 55) op = REQ_STATUS;
      else if (pick < 65) op = REQ_REMOVE;
      else if (pick < 77) op = REQ_EVICT;
      else if (pick < 95) op = REQ_QUERY;
      else op = 3'($urandom_range(7, 5));
      k = ($urandom_range(15) == 0) ? $urandom : key_pool[$urandom_range(23)];
      len = ($urandom_range(9) < 7) ? 20'($urandom_range(2000)) : 20'($urandom);
      send_item(op, k, len, 2'($urandom));
    end
  endtask

  initial begin
    foreach (key_pool[i]) key_pool[i] = $urandom;
    key_pool[0] = 32'h0;
    key_pool[1] = 32'hFFFF_FFFF;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;
    repeat (3) @(negedge clk_i);

    send_item(REQ_QUERY, 32'h0, '0, '0);
    send_item(REQ_UPDATE, 32'h0, 20'h0, '0);
    send_item(REQ_UPDATE, 32'hFFFF_FFFF, 20'hFFFFF, '0);
    send_item(REQ_UPDATE, 32'h1234_5678, 20'd5000, '0);
    send_item(REQ_QUERY, 32'hFFFF_FFFF, '0, '0);
    send_item(REQ_STATUS, 32'hFFFF_FFFF, '0, ST_OTHER);
    send_item(REQ_STATUS, 32'h0, '0, ST_PROCESSING);
    send_item(REQ_STATUS, 32'h1234_5678, '0, ST_COMPLETED);
    send_item(REQ_STATUS, 32'hDEAD_BEEF, '0, ST_OTHER);
    send_item(REQ_QUERY, 32'hDEAD_BEEF, '0, '0);
    send_item(REQ_EVICT, '0, '0, '0);
    send_item(REQ_QUERY, 32'hFFFF_FFFF, '0, '0);
    send_item(REQ_REMOVE, 32'h5555_AAAA, '0, '0);
    send_item(REQ_REMOVE, 32'hFFFF_FFFF, '0, '0);
    send_item(REQ_UPDATE, 32'h0, 20'd7, '0);
    send_item(REQ_UPDATE, 32'h0, 20'd9, '0);
    send_item(REQ_EVICT, '0, '0, '0);
    send_item(3'd5, 32'hAAAA_5555, 20'hAAAAA, ST_COMPLETED);
    send_item(3'd7, 32'h5555_AAAA, 20'h55555, ST_PROCESSING);
    send_item(REQ_QUERY, 32'h0, '0, '0);
    drain();

    apb_write(REG_MAX_ITEMS, 32'h00FF_FFFF);
    apb_write(REG_MAX_MEM, 32'h01FF_FFFF);
    apb_write(REG_FRACTION, 32'd256);
    send_random(55);
    drain();

    apb_write(REG_MAX_ITEMS, 32'd3000);
    apb_write(REG_MAX_MEM, 32'd6000);
    apb_write(REG_FRACTION, 32'd128);
    no_idle = 1;
    send_random(55);
    no_idle = 0;
    drain();

    apb_write(REG_MAX_ITEMS, 32'd0);
    apb_write(REG_MAX_MEM, 32'd0);
    apb_write(REG_FRACTION, 32'd0);
    send_random(50);
    drain();

    apb_write(REG_MAX_ITEMS, 32'd20000);
    apb_write(REG_MAX_MEM, 32'd9000);
    apb_write(REG_FRACTION, 32'd511);
    send_random(30);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    send_random(25);
    drain();

    apb_write(REG_MAX_ITEMS, 32'd16384);
    apb_write(REG_MAX_MEM, 32'd32768);
    apb_write(REG_FRACTION, 32'd230);
    send_random(35);
    drain();

    if (sb.pending_q.size() != 0) begin
      $error("%0d results never arrived", sb.pending_q.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
